### hdl/overwrite_fifo_with_zero_fill_defines.svh
// Assertion macros shared by the overwrite FIFO RTL.
// Depends on nothing; the using module must have signals named clk and rst.
`ifndef OVERWRITE_FIFO_WITH_ZERO_FILL_DEFINES_SVH
`define OVERWRITE_FIFO_WITH_ZERO_FILL_DEFINES_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define OFZ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("overwrite fifo: invariant violated");
// Consequent holds at the same edge as the antecedent.
`define OFZ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("overwrite fifo: implication violated");
// Consequent holds at the edge after the antecedent.
`define OFZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("overwrite fifo: next-cycle implication violated");
`else
`define OFZ_ASSERT_ALWAYS(lbl, cond)
`define OFZ_ASSERT_SAME(lbl, ante, cons)
`define OFZ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/ofz_pkg.sv
// Types, constants and helpers for the overwrite FIFO with zero fill.
// Depends on nothing; used by every module of the block.
package ofz_pkg;

  // Store geometry.
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [31:0]       sample_t;
  typedef logic [31:0]       level_t;

  localparam addr_t LAST_SLOT  = ADDR_W'(DEPTH - 1);
  localparam cnt_t  FULL_COUNT = CNT_W'(DEPTH);

  // Item actions, carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_PUSH      = 2'd0,
    ACT_PUSH_ZERO = 2'd1,
    ACT_POP       = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  // What a pop handed out, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  // One access to the sample memory.
  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata;
    logic    re;
    addr_t   raddr;
  } ram_req_t;

  // Result of one item, apart from the sample read from memory.
  typedef struct packed {
    kind_t  kind;
    logic   dropped;
    level_t level;
  } result_t;

  // Circular increment of a slot index.
  function automatic addr_t next_slot(input addr_t i);
    return (i == LAST_SLOT) ? '0 : addr_t'(i + 1'b1);
  endfunction

endpackage

### hdl/overwrite_fifo_with_zero_fill.sv
// Overwriting circular FIFO of packed I/Q samples with zero compensation.
// One item is accepted per clock and its result appears in the output register
// in the next cycle; s_tready drops only while that register holds a result that
// the sink has not taken. Each item makes at most one access to the sample
// memory (one write for a push, one read for a pop), so the memory's single
// write and single read port set the rate at one item per cycle. The store has
// no reset pass: the block accepts items from the first cycle after reset.
// Depends on ofz_pkg, ofz_ctrl and ofz_ram.
module overwrite_fifo_with_zero_fill (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_in[31:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // read_sample[31:0], dropped[32], fill_level[64:33], zero
  output logic [1:0]  m_tuser    // pop_kind[1:0]
);

  logic              fire;
  ofz_pkg::ram_req_t req;
  ofz_pkg::result_t  res;
  ofz_pkg::result_t  out_res;
  ofz_pkg::sample_t  rdata;
  ofz_pkg::sample_t  read_sample;

  // Accept whenever the output register is empty or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  ofz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .action    (ofz_pkg::action_t'(s_tuser)),
    .sample_in (s_tdata),
    .req       (req),
    .res       (res)
  );

  ofz_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Output register; the memory read data lands alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  // Only a stored-sample pop shows memory data.
  assign read_sample = (out_res.kind == ofz_pkg::KIND_SAMPLE) ? rdata : '0;
  assign m_tdata     = {7'b0, out_res.level, out_res.dropped, read_sample};
  assign m_tuser     = out_res.kind;

endmodule

### hdl/ofz_ram.sv
// Sample memory: one write port and one registered read port.
// Depends on ofz_pkg for the depth, the data types and the request struct.
module ofz_ram (
  input  logic              clk,
  input  ofz_pkg::ram_req_t req,
  output ofz_pkg::sample_t  rdata
);

  ofz_pkg::sample_t mem [ofz_pkg::DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### hdl/ofz_ctrl.sv
// Index, count and pending-zero bookkeeping; issues memory accesses per item.
// Depends on ofz_pkg and the assertion macros in the defines header.
`include "overwrite_fifo_with_zero_fill_defines.svh"
module ofz_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ofz_pkg::action_t  action,
  input  ofz_pkg::sample_t  sample_in,
  output ofz_pkg::ram_req_t req,
  output ofz_pkg::result_t  res
);

  ofz_pkg::addr_t write_index, write_index_next;
  ofz_pkg::addr_t read_index, read_index_next;
  ofz_pkg::cnt_t  stored_count, stored_count_next;
  logic [31:0]    zeros_pending, zeros_pending_next;
  logic [32:0]    level_sum;
  logic           full;

  assign full = (stored_count == ofz_pkg::FULL_COUNT);

  // Per-item update of the bookkeeping and the memory request.
  always_comb begin
    write_index_next   = write_index;
    read_index_next    = read_index;
    stored_count_next  = stored_count;
    zeros_pending_next = zeros_pending;
    req                = '0;
    res.kind           = ofz_pkg::KIND_NONE;
    res.dropped        = 1'b0;
    if (fire) begin
      case (action)
        ofz_pkg::ACT_PUSH, ofz_pkg::ACT_PUSH_ZERO: begin
          req.we           = 1'b1;
          req.waddr        = write_index;
          req.wdata        = (action == ofz_pkg::ACT_PUSH) ? sample_in : '0;
          write_index_next = ofz_pkg::next_slot(write_index);
          if (full) begin
            // Overwrite the oldest entry and owe one more zero.
            res.dropped     = 1'b1;
            read_index_next = ofz_pkg::next_slot(write_index);
            if (zeros_pending != '1) begin
              zeros_pending_next = zeros_pending + 32'd1;
            end
          end else begin
            stored_count_next = stored_count + 1'b1;
          end
        end
        ofz_pkg::ACT_POP: begin
          if (zeros_pending != '0) begin
            zeros_pending_next = zeros_pending - 32'd1;
            res.kind           = ofz_pkg::KIND_ZERO;
          end else if (stored_count != '0) begin
            req.re            = 1'b1;
            req.raddr         = read_index;
            read_index_next   = ofz_pkg::next_slot(read_index);
            stored_count_next = stored_count - 1'b1;
            res.kind          = ofz_pkg::KIND_SAMPLE;
          end
        end
        default: begin
          write_index_next   = '0;
          read_index_next    = '0;
          stored_count_next  = '0;
          zeros_pending_next = '0;
        end
      endcase
    end
    // Fill level after the item, saturating at 32 bits.
    level_sum = {1'b0, zeros_pending_next}
              + {{(33 - ofz_pkg::CNT_W){1'b0}}, stored_count_next};
    res.level = level_sum[32] ? '1 : level_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index   <= '0;
      read_index    <= '0;
      stored_count  <= '0;
      zeros_pending <= '0;
    end else begin
      write_index   <= write_index_next;
      read_index    <= read_index_next;
      stored_count  <= stored_count_next;
      zeros_pending <= zeros_pending_next;
    end
  end

  // Checks on the bookkeeping.
  `OFZ_ASSERT_ALWAYS(a_count_bound, stored_count <= ofz_pkg::FULL_COUNT)
  `OFZ_ASSERT_ALWAYS(a_full_indices, !full || (read_index == write_index))
  `OFZ_ASSERT_SAME(a_read_only_on_sample, req.re, res.kind == ofz_pkg::KIND_SAMPLE)
  `OFZ_ASSERT_NEXT(a_clear_empties, fire && (action == ofz_pkg::ACT_CLEAR),
                   (stored_count == '0) && (zeros_pending == '0))

endmodule

### dv/ofz_result_checker.sv
// Checker for the overwrite FIFO with zero fill: mirrors the FIFO state and scores every result.
// Depends on ofz_pkg for the store geometry, the action codes and the pop kinds.
module ofz_result_checker
  import ofz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_in[31:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // read_sample[31:0], dropped[32], fill_level[64:33], zero
  input  logic [1:0]  m_tuser,   // pop_kind[1:0]
  output int          fail_count,
  output int          results_due_count,
  output int          n_results,
  output int          n_overwrites,
  output int          n_zero_pops,
  output int          n_sample_pops,
  output int          n_empty_pops
);

  // Fields of one result item.
  typedef struct packed {
    sample_t sample;
    kind_t   kind;
    logic    dropped;
    level_t  level;
  } item_result_t;

  // Mirror of the FIFO state.
  sample_t      mirror_store [DEPTH];
  addr_t        mirror_wr;
  addr_t        mirror_rd;
  cnt_t         mirror_count;
  level_t       mirror_zeros;
  item_result_t results_due [$];

  // Circular step of a slot index.
  function automatic addr_t wrap_inc(input addr_t slot);
    return (slot == addr_t'(DEPTH - 1)) ? addr_t'(0) : addr_t'(slot + 1'b1);
  endfunction

  // Applies one item to the mirror and returns the result it must produce.
  function automatic item_result_t predict_item(input action_t act, input sample_t din);
    item_result_t res;
    logic [32:0]  total;
    res = '0;
    res.kind = KIND_NONE;
    case (act)
      ACT_PUSH, ACT_PUSH_ZERO: begin
        // A full store loses its oldest entry and owes one more zero.
        if (mirror_count == cnt_t'(DEPTH)) begin
          res.dropped = 1'b1;
          mirror_rd = wrap_inc(mirror_wr);
          if (mirror_zeros != '1) mirror_zeros = mirror_zeros + 1'b1;
        end else begin
          mirror_count = mirror_count + 1'b1;
        end
        mirror_store[mirror_wr] = (act == ACT_PUSH) ? din : '0;
        mirror_wr = wrap_inc(mirror_wr);
      end
      ACT_POP: begin
        // Owed zeros go out before any stored sample.
        if (mirror_zeros != '0) begin
          mirror_zeros = mirror_zeros - 1'b1;
          res.kind = KIND_ZERO;
        end else if (mirror_count != '0) begin
          res.sample = mirror_store[mirror_rd];
          res.kind = KIND_SAMPLE;
          mirror_rd = wrap_inc(mirror_rd);
          mirror_count = mirror_count - 1'b1;
        end
      end
      default: begin
        mirror_wr = '0;
        mirror_rd = '0;
        mirror_count = '0;
        mirror_zeros = '0;
      end
    endcase
    total = {1'b0, mirror_zeros} + 33'(mirror_count);
    res.level = total[32] ? '1 : total[31:0];
    return res;
  endfunction

  // Score results and predict accepted items at each rising edge.
  always @(posedge clk) begin : watch
    item_result_t exp_r;
    item_result_t got;
    logic         bad;
    if (rst) begin
      mirror_wr = '0;
      mirror_rd = '0;
      mirror_count = '0;
      mirror_zeros = '0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.sample = m_tdata[31:0];
        got.dropped = m_tdata[32];
        got.level = m_tdata[64:33];
        got.kind = kind_t'(m_tuser);
        n_results++;
        if (got.dropped === 1'b1) n_overwrites++;
        case (got.kind)
          KIND_ZERO:   n_zero_pops++;
          KIND_SAMPLE: n_sample_pops++;
          default:     ;
        endcase
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result item with nothing expected: sample=%h kind=%0d dropped=%b level=%0d",
                   $time, got.sample, got.kind, got.dropped, got.level);
        end else begin
          exp_r = results_due.pop_front();
          if (exp_r.kind == KIND_NONE && got.kind === KIND_NONE && m_tdata[32] === 1'b0)
            n_empty_pops += (exp_r.level == got.level) ? 0 : 0;
          bad = (got.sample !== exp_r.sample) || (got.kind !== exp_r.kind) ||
                (got.dropped !== exp_r.dropped) || (got.level !== exp_r.level) ||
                (m_tdata[71:65] !== '0);
          if (bad) begin
            fail_count++;
            $display("%0t: mismatch expected sample=%h kind=%0d dropped=%b level=%0d",
                     $time, exp_r.sample, exp_r.kind, exp_r.dropped, exp_r.level);
            $display("%0t:          actual   sample=%h kind=%0d dropped=%b level=%0d pad=%h",
                     $time, got.sample, got.kind, got.dropped, got.level, m_tdata[71:65]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        // A pop on an empty FIFO is counted when it is predicted.
        exp_r = predict_item(action_t'(s_tuser), s_tdata);
        if (action_t'(s_tuser) == ACT_POP && exp_r.kind == KIND_NONE) n_empty_pops++;
        results_due.push_back(exp_r);
      end
    end
    results_due_count = results_due.size();
  end

endmodule

### dv/overwrite_fifo_with_zero_fill_tb.sv
// Top of the overwrite FIFO testbench: clock, reset, item stimulus with random idling, verdict.
// Depends on ofz_pkg, the overwrite_fifo_with_zero_fill block and ofz_result_checker.
module overwrite_fifo_with_zero_fill_tb;
  import ofz_pkg::*;

  localparam int RANDOM_ITEMS   = 200;
  localparam int OVERFLOW_SMALL = 40;

  // Action mixes of a random burst.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = ACT_PUSH;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  bit s_fire;
  bit m_fire;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  int fail_count;
  int results_due_count;
  int n_results;
  int n_overwrites;
  int n_zero_pops;
  int n_sample_pops;
  int n_empty_pops;

  always #5 clk = ~clk;

  // Handshakes seen at the rising edge, read by the drivers at the falling edge.
  always @(posedge clk) begin
    s_fire <= s_tvalid && s_tready;
    m_fire <= m_tvalid && m_tready;
  end

  overwrite_fifo_with_zero_fill u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ofz_result_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tuser           (s_tuser),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .fail_count        (fail_count),
    .results_due_count (results_due_count),
    .n_results         (n_results),
    .n_overwrites      (n_overwrites),
    .n_zero_pops       (n_zero_pops),
    .n_sample_pops     (n_sample_pops),
    .n_empty_pops      (n_empty_pops)
  );

  // Sample values with the extremes drawn often.
  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Action drawn from the weights of a burst mix; clears stay rare.
  function automatic action_t pick_action(input mix_t mix);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  push_pct = 75;
      MIX_DRAIN: push_pct = 25;
      default:   push_pct = 50;
    endcase
    if (r == 0) return ACT_CLEAR;
    if (r <= push_pct) return ($urandom_range(0, 5) == 0) ? ACT_PUSH_ZERO : ACT_PUSH;
    return ACT_POP;
  endfunction

  // Offers one item, after a random gap while tx_idle is set, and returns once it has been taken.
  task automatic send_item(input action_t act, input sample_t data);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= data;
    do @(negedge clk); while (!s_fire);
  endtask

  // Holds the input off until every outstanding result has been taken.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (results_due_count != 0);
  endtask

  // Pushes a random mix of samples and zeros.
  task automatic push_run(input int count);
    repeat (count) begin
      send_item(($urandom_range(0, 7) == 0) ? ACT_PUSH_ZERO : ACT_PUSH, random_sample());
    end
  endtask

  // Sink: a random stall before each result item, with stall-free stretches.
  initial begin : sink
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_fire);
    end
  end

  // Run limit far above the slowest correct run.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int   issued;
    int   burst;
    mix_t mix;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pop, extreme samples, zero push, ordered pops, clear.
    send_item(ACT_POP, $urandom);
    send_item(ACT_PUSH, 32'h0000_0000);
    send_item(ACT_PUSH, 32'hFFFF_FFFF);
    send_item(ACT_PUSH, 32'h0000_FFFF);
    send_item(ACT_PUSH, 32'hFFFF_0000);
    send_item(ACT_PUSH_ZERO, 32'hDEAD_BEEF);
    send_item(ACT_PUSH, 32'h0000_0001);
    send_item(ACT_PUSH, 32'h8000_0000);
    repeat (7) send_item(ACT_POP, $urandom);
    send_item(ACT_POP, $urandom);
    send_item(ACT_PUSH, 32'h5555_AAAA);
    send_item(ACT_CLEAR, $urandom);
    send_item(ACT_POP, $urandom);
    send_item(ACT_CLEAR, $urandom);
    wait_drain();

    // Fill the store, then overwrite its oldest entries; pops give the owed zeros first.
    push_run(DEPTH + OVERFLOW_SMALL);
    repeat (OVERFLOW_SMALL + 20) send_item(ACT_POP, $urandom);

    // Random bursts with their own mix and idling pattern.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(10, 60);
      repeat (burst) send_item(pick_action(mix), random_sample());
      issued += burst;
    end

    wait_drain();
    repeat (10) @(negedge clk);
    $display("Run covered %0d result items: %0d overwriting pushes, %0d owed zeros popped,",
             n_results, n_overwrites, n_zero_pops);
    $display("%0d stored samples popped and %0d pops from an empty FIFO.",
             n_sample_pops, n_empty_pops);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
